// ===== rtl/lpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types and constants of the length-prefixed string deframer.
// ----------------------------------------------------------------------------
package lpsd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned SizeW = 17;

  // ASCII code of the digit zero and the radix of the length field.
  localparam logic [ByteW-1:0] AsciiZero = 8'd48;
  localparam logic [ByteW-1:0] AsciiNine = 8'd57;
  localparam int unsigned      Radix     = 10;

  // Length and frame size saturate at the largest 17-bit value.
  localparam logic [SizeW-1:0] SizeSat = {SizeW{1'b1}};

  // Frame parsing phase.
  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // One result item.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             empty;
    logic [SizeW-1:0] size;
    logic             error;
  } res_t;

endpackage

// ===== rtl/length_prefixed_string_deframer_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_string_deframer_core
// Splits a byte stream of frames, each a prefix digit, that many decimal
// length digits and a payload, into payload bytes with last and size marks.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid/in_ready    in_byte
//  out      source     out_valid/out_ready  out_byte, out_last, out_empty,
//                                           frame_size, frame_error
//
// One byte is accepted per cycle while the skid stage is empty; its result,
// if any, is registered in the output register or, if that is held, the skid
// stage. The frame state and a single digit multiply-add sit between the
// input handshake and this two-entry output buffer, so a waiting result in
// the output register does not stall the next byte. Reset clears the frame
// state and empties both output entries; no clearing pass is needed.
// ----------------------------------------------------------------------------
module length_prefixed_string_deframer_core #(
  parameter int unsigned MAX_LEN_DIGITS = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lpsd_pkg::ByteW-1:0] in_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lpsd_pkg::ByteW-1:0] out_byte_o,
  output logic                      out_last_o,
  output logic                      out_empty_o,
  output logic [lpsd_pkg::SizeW-1:0] frame_size_o,
  output logic                      frame_error_o
);
  import lpsd_pkg::*;

  localparam int unsigned DlW = $clog2(MAX_LEN_DIGITS + 1);
  localparam int unsigned HbW = $clog2(MAX_LEN_DIGITS + 2);
  localparam int unsigned MulW = SizeW + 4;
  localparam logic [ByteW-1:0] PrefixMin = 8'(AsciiZero + 8'd1);
  localparam logic [ByteW-1:0] PrefixMax = 8'(AsciiZero + MAX_LEN_DIGITS);
  localparam logic [SizeW-1:0] AccLimit  = SizeW'(SizeSat / Radix);

  // Frame state.
  phase_e           phase_q, phase_d;
  logic [DlW-1:0]   digits_left_q, digits_left_d;
  logic [SizeW-1:0] length_accum_q, length_accum_d;
  logic [SizeW-1:0] payload_left_q, payload_left_d;
  logic [HbW-1:0]   header_bytes_q, header_bytes_d;

  // Output buffer.
  res_t out_q, skid_q, res;
  logic out_valid_q, skid_valid_q;
  logic res_valid;

  logic in_fire, out_fire;
  logic is_digit, is_prefix;
  logic [ByteW-1:0] digit_val;
  logic [MulW-1:0]  accum_x10, accum_sum;
  logic [SizeW-1:0] accum_next;
  logic [DlW-1:0]   digits_dec;
  logic [SizeW-1:0] payload_dec;
  logic [SizeW:0]   size_sum;
  logic [SizeW-1:0] size_sat;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // Byte classification and the length digit multiply-add.
  assign is_digit  = (in_byte_i >= AsciiZero) && (in_byte_i <= AsciiNine);
  assign is_prefix = (in_byte_i >= PrefixMin) && (in_byte_i <= PrefixMax);
  assign digit_val = in_byte_i - AsciiZero;
  assign accum_x10 = {1'b0, length_accum_q, 3'b000} + {3'b000, length_accum_q, 1'b0};
  assign accum_sum = accum_x10 + MulW'(digit_val[3:0]);
  assign accum_next = ((length_accum_q > AccLimit) || (accum_sum > MulW'(SizeSat))) ?
                      SizeSat : accum_sum[SizeW-1:0];

  assign digits_dec  = (digits_left_q != '0) ? digits_left_q - 1'b1 : digits_left_q;
  assign payload_dec = (payload_left_q != '0) ? payload_left_q - 1'b1 : payload_left_q;

  // Frame size with saturation.
  assign size_sum = {1'b0, length_accum_q} + (SizeW + 1)'(header_bytes_q);
  assign size_sat = size_sum[SizeW] ? SizeSat : size_sum[SizeW-1:0];

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_DIGITS: begin
        if (!is_digit) begin
          phase_d = PH_PREFIX;
        end else if (digits_dec == '0) begin
          phase_d = (accum_next == '0) ? PH_PREFIX : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (payload_dec == '0) begin
          phase_d = PH_PREFIX;
        end
      end
      default: begin
        phase_d = is_prefix ? PH_DIGITS : PH_PREFIX;
      end
    endcase
  end

  // Datapath updates and the result of the current byte.
  always_comb begin
    digits_left_d  = digits_left_q;
    length_accum_d = length_accum_q;
    payload_left_d = payload_left_q;
    header_bytes_d = header_bytes_q;
    res            = '0;
    res_valid      = 1'b0;
    case (phase_q)
      PH_DIGITS: begin
        if (!is_digit) begin
          digits_left_d  = '0;
          length_accum_d = '0;
          res.error      = 1'b1;
          res_valid      = 1'b1;
        end else begin
          length_accum_d = accum_next;
          digits_left_d  = digits_dec;
          if (digits_dec == '0) begin
            if (accum_next == '0) begin
              res.last  = 1'b1;
              res.empty = 1'b1;
              res.size  = SizeW'(header_bytes_q);
              res_valid = 1'b1;
            end else begin
              payload_left_d = accum_next;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        payload_left_d = payload_dec;
        res.data       = in_byte_i;
        res_valid      = 1'b1;
        if (payload_dec == '0) begin
          res.last = 1'b1;
          res.size = size_sat;
        end
      end
      default: begin
        if (is_prefix) begin
          digits_left_d  = digit_val[DlW-1:0];
          header_bytes_d = HbW'(digit_val[3:0]) + 1'b1;
          length_accum_d = '0;
          payload_left_d = '0;
        end else begin
          res.error = 1'b1;
          res_valid = 1'b1;
        end
      end
    endcase
  end

  // Frame state registers, updated on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_PREFIX;
      digits_left_q  <= '0;
      length_accum_q <= '0;
      payload_left_q <= '0;
      header_bytes_q <= '0;
    end else if (in_fire) begin
      phase_q        <= phase_d;
      digits_left_q  <= digits_left_d;
      length_accum_q <= length_accum_d;
      payload_left_q <= payload_left_d;
      header_bytes_q <= header_bytes_d;
    end
  end

  // Output register and skid stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register and skid stage payload.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_q.data;
  assign out_last_o    = out_q.last;
  assign out_empty_o   = out_q.empty;
  assign frame_size_o  = out_q.size;
  assign frame_error_o = out_q.error;

endmodule

// ===== rtl/lpsd_checker.sv =====
// ----------------------------------------------------------------------------
// lpsd_checker
// Port-level checks of the deframer's result channel, bound to the deframer core.
// ----------------------------------------------------------------------------
module lpsd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [lpsd_pkg::ByteW-1:0] out_byte_o,
  input logic                       out_last_o,
  input logic                       out_empty_o,
  input logic [lpsd_pkg::SizeW-1:0] frame_size_o,
  input logic                       frame_error_o
);
  import lpsd_pkg::*;

  // A stalled result transaction holds its valid, byte, last, size and error fields.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(out_last_o) && $stable(frame_size_o) && $stable(frame_error_o))
    else $error("result changed while stalled");

  // An empty-frame marker is a last mark with no data byte.
  a_empty_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_empty_o |-> out_last_o && (out_byte_o == '0) && !frame_error_o)
    else $error("malformed empty-frame marker");

  // An error result carries nothing else.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_error_o |-> !out_last_o && !out_empty_o &&
    (out_byte_o == '0) && (frame_size_o == '0))
    else $error("error result carries payload");

  // The frame size is only reported with the last mark, and then covers a header.
  a_size_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_error_o |->
    (out_last_o ? (frame_size_o >= SizeW'(2)) : (frame_size_o == '0)))
    else $error("frame size outside last mark");

endmodule

bind length_prefixed_string_deframer_core lpsd_checker u_lpsd_checker (.*);
